@@ rtl/fsk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsk_pkg: shared types and constants of the FSK tape byte modulator
// Register map, request codes, pipeline types and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
package fsk_pkg;

   localparam int MAX_PERIOD       = 1023;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int ROM_AW           = $clog2(SINE_TABLE_DEPTH + 1);

   localparam int PER_W  = 10;
   localparam int STEP_W = 16;
   localparam int AMP_W  = 15;
   localparam int WORD_W = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [AMP_W-1:0] AMP8_MAX   = AMP_W'(127);
   localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic SHAPE_SQUARE = 1'b0;
   localparam logic SHAPE_SINE   = 1'b1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_WAVE_SHAPE      = 3'd0,
      CSR_SAMPLE_16BIT    = 3'd1,
      CSR_AMPLITUDE       = 3'd2,
      CSR_INVERT          = 3'd3,
      CSR_ZERO_PERIOD     = 3'd4,
      CSR_ONE_PERIOD      = 3'd5,
      CSR_ZERO_PHASE_STEP = 3'd6,
      CSR_ONE_PHASE_STEP  = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic              wave_shape;
      logic              sample_16bit;
      logic [AMP_W-1:0]  amplitude;
      logic              invert;
      logic [PER_W-1:0]  zero_period;
      logic [PER_W-1:0]  one_period;
      logic [STEP_W-1:0] zero_phase_step;
      logic [STEP_W-1:0] one_phase_step;
   } cfg_type;

   typedef struct packed {
      logic               shape;
      logic signed [15:0] value;
      logic               bit_end;
      logic               byte_end;
   } smp_type;

   typedef logic [14:0] rom_type [0:SINE_TABLE_DEPTH];

   function automatic logic [AMP_W-1:0] amp_eff(input cfg_type cfg);
      logic [AMP_W-1:0] a;
      a = cfg.amplitude;
      if (!cfg.sample_16bit && a > AMP8_MAX) a = AMP8_MAX;
      return a;
   endfunction

   function automatic logic [63:0] sq_term(input logic [63:0] t, input logic [63:0] x);
      logic [63:0] r;
      r = (t * x) >> 30;
      r = (r * x) >> 30;
      return r;
   endfunction

   function automatic logic [14:0] rom_entry_f(input int k);
      logic [63:0]        x;
      logic [63:0]        t;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      x   = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      t   = x;
      sum = signed'(x);
      t   = sq_term(t, x) / 6;
      sum = sum - signed'(t);
      t   = sq_term(t, x) / 20;
      sum = sum + signed'(t);
      t   = sq_term(t, x) / 42;
      sum = sum - signed'(t);
      t   = sq_term(t, x) / 72;
      sum = sum + signed'(t);
      t   = sq_term(t, x) / 110;
      sum = sum - signed'(t);
      t   = sq_term(t, x) / 156;
      sum = sum + signed'(t);
      if (sum < 0) sum = 0;
      v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 64'sd32767) v = 64'sd32767;
      return v[14:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         r[k] = rom_entry_f(k);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage
`default_nettype wire

@@ rtl/fsk_tape_byte_modulator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsk_tape_byte_modulator: FSK cassette tape byte modulator
// Sends a loaded byte MSB first as one square or sine cycle per bit.
// ----------------------------------------------------------------------------
// A load request (req_tuser = 0) takes a byte when the block is idle; each
// tick request (req_tuser = 1) then gives one sample on rsp, one request per
// clock cycle while rsp_tready allows. The sequencer registers the waveform
// value and counters, the output stage the scaled, formatted sample. A load
// while busy and a tick while idle give no response. rsp_tuser flags the
// last sample of a bit, rsp_tlast the last sample of the byte.
// ----------------------------------------------------------------------------
module fsk_tape_byte_modulator (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // data_byte
   input  wire logic                       req_tuser,   // action
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata,   // sample_word
   output logic                            rsp_tuser,   // bit_end
   output logic                            rsp_tlast,   // byte_end
   input  wire logic                       csr_we,
   input  wire logic [fsk_pkg::CSR_AW-1:0] csr_index,
   input  wire logic [fsk_pkg::CSR_DW-1:0] csr_wdata
);

   fsk_pkg::cfg_type cfg;
   fsk_pkg::smp_type smp;
   logic             smp_valid;
   logic             smp_ready;

   fsk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fsk_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .smp_valid  (smp_valid),
      .smp        (smp),
      .smp_ready  (smp_ready)
   );

   fsk_out u_out (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .smp_valid  (smp_valid),
      .smp        (smp),
      .smp_ready  (smp_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ rtl/fsk_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsk_csr: configuration registers
// Write-only register file loaded through the csr write port.
// ----------------------------------------------------------------------------
module fsk_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [fsk_pkg::CSR_AW-1:0] csr_index,
   input  wire logic [fsk_pkg::CSR_DW-1:0] csr_wdata,
   output fsk_pkg::cfg_type                cfg
);

   fsk_pkg::cfg_type cfg_ff;
   fsk_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (fsk_pkg::csr_idx_type'(csr_index))
            fsk_pkg::CSR_WAVE_SHAPE:      cfg_in.wave_shape      = csr_wdata[0];
            fsk_pkg::CSR_SAMPLE_16BIT:    cfg_in.sample_16bit    = csr_wdata[0];
            fsk_pkg::CSR_AMPLITUDE:       cfg_in.amplitude       =
                                             csr_wdata[fsk_pkg::AMP_W-1:0];
            fsk_pkg::CSR_INVERT:          cfg_in.invert          = csr_wdata[0];
            fsk_pkg::CSR_ZERO_PERIOD:     cfg_in.zero_period     =
                                             csr_wdata[fsk_pkg::PER_W-1:0];
            fsk_pkg::CSR_ONE_PERIOD:      cfg_in.one_period      =
                                             csr_wdata[fsk_pkg::PER_W-1:0];
            fsk_pkg::CSR_ZERO_PHASE_STEP: cfg_in.zero_phase_step =
                                             csr_wdata[fsk_pkg::STEP_W-1:0];
            fsk_pkg::CSR_ONE_PHASE_STEP:  cfg_in.one_phase_step  =
                                             csr_wdata[fsk_pkg::STEP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_shape      <= fsk_pkg::SHAPE_SINE;
         cfg_ff.sample_16bit    <= 1'b0;
         cfg_ff.amplitude       <= fsk_pkg::AMP_W'(127);
         cfg_ff.invert          <= 1'b0;
         cfg_ff.zero_period     <= fsk_pkg::PER_W'(22);
         cfg_ff.one_period      <= fsk_pkg::PER_W'(44);
         cfg_ff.zero_phase_step <= fsk_pkg::STEP_W'(2979);
         cfg_ff.one_phase_step  <= fsk_pkg::STEP_W'(1489);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/fsk_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsk_seq: bit sequencer and waveform lookup
// Holds the byte shift register, the bit and sample counters and the phase accumulator, and
// registers the raw waveform value of each tick for the output stage.
// ----------------------------------------------------------------------------
module fsk_seq (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire fsk_pkg::cfg_type cfg,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_tuser,
   input  wire logic [7:0] req_tdata,
   output logic            smp_valid,
   output fsk_pkg::smp_type smp,
   input  wire logic       smp_ready
);

   logic [7:0]                  shift_ff, shift_in;
   logic [2:0]                  bitcnt_ff, bitcnt_in;
   logic [fsk_pkg::PER_W-1:0]   sidx_ff, sidx_in;
   logic [fsk_pkg::STEP_W-1:0]  phase_ff, phase_in;
   logic                        busy_ff, busy_in;
   logic                        smp_valid_ff, smp_valid_in;
   fsk_pkg::smp_type            smp_ff, smp_in;

   logic                        accept;
   logic                        tick;
   logic                        cur_bit;
   logic [fsk_pkg::PER_W-1:0]   period;
   logic [fsk_pkg::STEP_W-1:0]  step;
   logic [fsk_pkg::AMP_W-1:0]   amp;
   logic                        high;
   logic                        bend;
   logic [fsk_pkg::ROM_AW-1:0]  ridx;
   logic [fsk_pkg::ROM_AW-1:0]  raddr;
   logic signed [15:0]          mag;
   logic signed [15:0]          sine;
   logic signed [15:0]          amp_s;

   assign req_tready = !smp_valid_ff || smp_ready;
   assign accept     = req_tvalid && req_tready;
   assign tick       = accept && (req_tuser == fsk_pkg::ACT_TICK) && busy_ff;

   always_comb begin
      cur_bit = shift_ff[7];
      period  = cur_bit ? cfg.one_period : cfg.zero_period;
      if (period < fsk_pkg::PER_W'(2)) period = fsk_pkg::PER_W'(2);
      if (32'(period) > fsk_pkg::MAX_PERIOD) period = fsk_pkg::PER_W'(fsk_pkg::MAX_PERIOD);
      step  = cur_bit ? cfg.one_phase_step : cfg.zero_phase_step;
      amp   = fsk_pkg::amp_eff(cfg);
      amp_s = $signed({1'b0, amp});
      high  = (sidx_ff < (period >> 1)) ^ cfg.invert;
      bend  = ({1'b0, sidx_ff} + 11'd1) >= {1'b0, period};

      ridx  = fsk_pkg::ROM_AW'((32'(phase_ff[13:0]) * fsk_pkg::SINE_TABLE_DEPTH) >> 14);
      raddr = phase_ff[14] ? (fsk_pkg::ROM_AW'(fsk_pkg::SINE_TABLE_DEPTH) - ridx) : ridx;
      mag   = $signed({1'b0, fsk_pkg::SINE_ROM[raddr]});
      sine  = (phase_ff[15] ^ cfg.invert) ? -mag : mag;
   end

   always_comb begin
      shift_in     = shift_ff;
      bitcnt_in    = bitcnt_ff;
      sidx_in      = sidx_ff;
      phase_in     = phase_ff;
      busy_in      = busy_ff;
      smp_valid_in = smp_valid_ff && !smp_ready;
      smp_in       = smp_ff;
      if (accept && (req_tuser == fsk_pkg::ACT_LOAD) && !busy_ff) begin
         shift_in  = req_tdata;
         bitcnt_in = 3'd0;
         sidx_in   = '0;
         phase_in  = '0;
         busy_in   = 1'b1;
      end
      if (tick) begin
         smp_valid_in    = 1'b1;
         smp_in.shape    = cfg.wave_shape;
         smp_in.value    = (cfg.wave_shape == fsk_pkg::SHAPE_SINE) ? sine
                           : (high ? amp_s : -amp_s);
         smp_in.bit_end  = bend;
         smp_in.byte_end = bend && (bitcnt_ff == 3'd7);
         if (bend) begin
            shift_in  = {shift_ff[6:0], 1'b0};
            bitcnt_in = bitcnt_ff + 3'd1;
            sidx_in   = '0;
            phase_in  = '0;
            if (bitcnt_ff == 3'd7) busy_in = 1'b0;
         end else begin
            sidx_in  = sidx_ff + fsk_pkg::PER_W'(1);
            phase_in = phase_ff + step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bitcnt_ff    <= '0;
         sidx_ff      <= '0;
         phase_ff     <= '0;
         busy_ff      <= 1'b0;
         smp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         bitcnt_ff    <= bitcnt_in;
         sidx_ff      <= sidx_in;
         phase_ff     <= phase_in;
         busy_ff      <= busy_in;
         smp_valid_ff <= smp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
   end

   assign smp_valid = smp_valid_ff;
   assign smp       = smp_ff;

endmodule
`default_nettype wire

@@ rtl/fsk_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsk_out: amplitude scaling and sample formatting
// Scales the sine value by the amplitude, formats 8-bit offset or 16-bit
// signed samples and holds the result register of the rsp channel.
// ----------------------------------------------------------------------------
module fsk_out (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fsk_pkg::cfg_type cfg,
   input  wire logic        smp_valid,
   input  wire fsk_pkg::smp_type smp,
   output logic             smp_ready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   logic               valid_ff, valid_in;
   logic [15:0]        word_ff, word_in;
   logic               bend_ff, yend_ff;

   logic signed [31:0] prod;
   logic signed [31:0] neg;
   logic signed [31:0] scaled;
   logic signed [15:0] val;

   assign smp_ready = !valid_ff || rsp_tready;

   always_comb begin
      prod = $signed({17'd0, fsk_pkg::amp_eff(cfg)}) * 32'(smp.value);
      neg  = -prod;
      if (prod >= 0 || !cfg.sample_16bit) begin
         scaled = prod >>> 15;
      end else begin
         scaled = -(neg >>> 15);
      end
      val = (smp.shape == fsk_pkg::SHAPE_SINE) ? scaled[15:0] : smp.value;
      if (cfg.sample_16bit) begin
         word_in = val;
      end else begin
         word_in = {8'h00, 8'h80 + val[7:0]};
      end
      valid_in = smp_valid || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (smp_valid && smp_ready) begin
         word_ff <= word_in;
         bend_ff <= smp.bit_end;
         yend_ff <= smp.byte_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff;
   assign rsp_tuser  = bend_ff;
   assign rsp_tlast  = yend_ff;

endmodule
`default_nettype wire
